### rtl/tkx_pkg.sv
// shared types, widths and constants of the table keystream xor cipher
package tkx_pkg;

  // field and register widths
  localparam int KEY_W   = 24;
  localparam int LEN_W   = 15;
  localparam int TADDR_W = 14;
  localparam int TVAL_W  = 7;
  localparam int CHAR_W  = 8;
  localparam int OPOS_W  = 6;

  // reset values of the configuration registers
  localparam logic [KEY_W-1:0] KEY_RESET = 24'h060899;
  localparam logic [LEN_W-1:0] LEN_RESET = 15'd10000;

  // cipher constants
  localparam int REDUCE_MOD = 94;
  localparam int CHAR_SHIFT = 32;

  // shared modulo unit: dividend covers position + key + running value
  localparam int NUM_W = KEY_W + 2;
  localparam int DEN_W = LEN_W;
  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W);

  // running value mod 94 by reciprocal multiply, exact for any 24-bit value:
  // floor(x / 94) == ((x >> 1) * RV_RECIP) >> RV_RECIP_SH
  localparam logic [KEY_W-1:0] RV_RECIP = 24'd11422786;
  localparam int RV_RECIP_SH = 29;
  localparam int RV_PROD_W   = 2 * KEY_W - 1;
  localparam int RV_QUO_W    = RV_PROD_W - RV_RECIP_SH;

  // default sizes handed down from the top level
  localparam int TABLE_DEPTH_DEF = 16384;
  localparam int MESSAGE_LEN_DEF = 64;
  localparam int ROUNDS_DEF      = 8;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_CIPHER = 1'b1;

  // apb register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_KEY = 1'b0;
  localparam logic REG_LEN = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [TADDR_W-1:0] table_addr;
    logic [TVAL_W-1:0]  table_value;
    logic [CHAR_W-1:0]  data_char;
    logic               first_char;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [OPOS_W-1:0] out_position;
  } out_res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/table_keystream_xor_cipher_unit.sv
// Table keystream xor cipher: one load or one character at a time.
// A load request is written into the table as it is taken. Each cipher round starts the
// 26-bit bit-serial index modulo, waits for its remainder and mixes in the table read; a
// key-seeded first round with a key of 128 or more adds a reciprocal mod 94 step. The next
// request is taken once the result is raised; the finish state waits while an earlier result is unread.
// Synchronous active-low reset: key and length registers reload, position and running value clear.
module table_keystream_xor_cipher_unit #(
  parameter int TABLE_DEPTH = tkx_pkg::TABLE_DEPTH_DEF,
  parameter int MESSAGE_LEN = tkx_pkg::MESSAGE_LEN_DEF,
  parameter int ROUNDS      = tkx_pkg::ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tkx_pkg::in_req_t           in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output tkx_pkg::out_res_t          out_data,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkx_pkg::APB_AW-1:0] paddr,
  input  logic [tkx_pkg::APB_DW-1:0] pwdata,
  output logic [tkx_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import tkx_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int POS_W = (MESSAGE_LEN > 1) ? $clog2(MESSAGE_LEN) : 1;
  localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int RV_W  = KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX_GO,
    S_IDX_WAIT,
    S_MIX,
    S_RV_MUL,
    S_RV_SUB,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RV_W-1:0]     rv_r, rv_nxt;
  logic [RV_QUO_W-1:0] rv_quo_r, rv_quo_nxt;
  logic [CHAR_W-1:0]   v_r, v_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_res_t            out_data_r, out_data_nxt;

  logic                 cfg_wr;
  logic                 in_acc;
  logic [LEN_W-1:0]     eff_len;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 ram_we;
  logic                 ram_re;
  logic [TVAL_W-1:0]    ram_rdata;
  logic [TVAL_W-1:0]    sr;
  logic [TVAL_W-1:0]    rv_small;
  logic [RV_PROD_W-1:0] rv_prod;
  logic                 round_done;
  logic                 last_round;

  // apb register writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    key_nxt = key_r;
    len_nxt = len_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_KEY: key_nxt = pwdata[KEY_W-1:0];
        REG_LEN: len_nxt = pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KEY: prdata = APB_DW'(key_r);
      REG_LEN: prdata = APB_DW'(len_r);
      default: prdata = '0;
    endcase
  end

  // table length clamped to 1..TABLE_DEPTH
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if ({2'b00, len_r} > (LEN_W + 2)'(TABLE_DEPTH)) begin
      eff_len = LEN_W'(TABLE_DEPTH);
    end else begin
      eff_len = len_r;
    end
  end

  // request handshake and table loads
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ram_we   = in_acc && (in_data.req_type == REQ_LOAD) &&
                    ({3'b000, in_data.table_addr} < (TADDR_W + 3)'(TABLE_DEPTH));
  assign ram_re   = (state_r == S_IDX_WAIT) && div_rsp.done;

  // table value mod 94 and small running value update
  assign sr       = (ram_rdata >= TVAL_W'(REDUCE_MOD)) ?
                    (ram_rdata - TVAL_W'(REDUCE_MOD)) : ram_rdata;
  assign rv_small = ((rv_r[TVAL_W-1:0] ^ sr) >= TVAL_W'(REDUCE_MOD)) ?
                    ((rv_r[TVAL_W-1:0] ^ sr) - TVAL_W'(REDUCE_MOD)) :
                    (rv_r[TVAL_W-1:0] ^ sr);
  assign last_round = (rnd_r == RND_W'(ROUNDS - 1));

  // quotient of a wide running value by 94 through the reciprocal
  assign rv_prod = RV_PROD_W'(rv_r[RV_W-1:1]) * RV_PROD_W'(RV_RECIP);

  // round sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rv_nxt        = rv_r;
    rv_quo_nxt    = rv_quo_r;
    v_nxt         = v_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(pos_r) + NUM_W'(key_r) + NUM_W'(rv_r);
    div_req.den   = eff_len;
    round_done    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_CIPHER)) begin
          if (in_data.first_char) begin
            pos_nxt = '0;
            rv_nxt  = key_r;
          end
          v_nxt     = in_data.data_char - CHAR_W'(CHAR_SHIFT);
          rnd_nxt   = '0;
          state_nxt = S_IDX_GO;
        end
      end
      S_IDX_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_IDX_WAIT;
      end
      S_IDX_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        v_nxt = v_r ^ CHAR_W'(sr);
        if (rv_r[RV_W-1:TVAL_W] == '0) begin
          rv_nxt     = RV_W'(rv_small);
          round_done = 1'b1;
        end else begin
          // wide running value: keep the xor and reduce it in the multiply and subtract states
          rv_nxt    = rv_r ^ RV_W'(sr);
          state_nxt = S_RV_MUL;
        end
      end
      S_RV_MUL: begin
        rv_quo_nxt = rv_prod[RV_RECIP_SH +: RV_QUO_W];
        state_nxt  = S_RV_SUB;
      end
      S_RV_SUB: begin
        rv_nxt     = rv_r - RV_W'(rv_quo_r) * RV_W'(REDUCE_MOD);
        round_done = 1'b1;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_char     = v_r + CHAR_W'(CHAR_SHIFT);
          out_data_nxt.out_position = OPOS_W'(pos_r);
          pos_nxt   = (pos_r == POS_W'(MESSAGE_LEN - 1)) ? '0 : pos_r + POS_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance to the next round or finish the character
    if (round_done) begin
      if (last_round) begin
        rnd_nxt   = '0;
        state_nxt = S_FIN;
      end else begin
        rnd_nxt   = rnd_r + RND_W'(1);
        state_nxt = S_IDX_GO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= KEY_RESET;
      len_r       <= LEN_RESET;
      pos_r       <= '0;
      rv_r        <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      rv_r        <= rv_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r        <= v_nxt;
    rv_quo_r   <= rv_quo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared modulo unit
  tkx_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // keystream table
  tkx_table_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_data.table_addr)),
    .wr_data (in_data.table_value),
    .rd_en   (ram_re),
    .rd_addr (AW'(div_rsp.rem)),
    .rd_data (ram_rdata)
  );

  // modulo results arrive only while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_IDX_WAIT))
    else $error("modulo unit finished outside a wait state");

  // a table index is always below the effective table length
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDX_WAIT && div_rsp.done) |-> (div_rsp.rem < REM_W'(eff_len)))
    else $error("table index not reduced below table length");

  // a result appears only out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

endmodule

### rtl/tkx_mod_unit.sv
// shared restoring modulo unit, one remainder bit per cycle
module tkx_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tkx_pkg::div_req_t req,
  output tkx_pkg::div_rsp_t rsp
);
  import tkx_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
      end else begin
        rem_nxt = trial;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/tkx_table_ram.sv
// keystream table memory, one write and one registered read port
module tkx_table_ram #(
  parameter int DEPTH = tkx_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [tkx_pkg::TVAL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [tkx_pkg::TVAL_W-1:0] rd_data
);
  import tkx_pkg::*;

  logic [TVAL_W-1:0] mem [DEPTH];
  logic [TVAL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
